/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the height track table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/htt_pkg.sv */
// ----------------------------------------------------------------------------
// htt_pkg
// Shared widths, codes and control types of the height track table.
// ----------------------------------------------------------------------------
package htt_pkg;

  localparam int ID_W   = 32;
  localparam int Z_W    = 32;
  localparam int CFG_W  = 5;
  localparam int ADDR_W = 3;
  localparam int APB_W  = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic OP_TRACK = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic REG_ENTRIES_IN_USE = 1'b0;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } htt_mem_ctl_t;

endpackage

/* rtl/height_track_table.sv */
// ----------------------------------------------------------------------------
// height_track_table
// Identifier/height table with sequential search, first-free fill and
// modulo eviction. One item at a time through a small sequencer.
// Clear, rejected and empty-range items go straight to the result. A track
//   item searches entries in order and updates a hit, else fills the first
//   free entry or evicts at the index from the 32-step bit-serial remainder
//   unit started at accept. A new item waits until the last result is in the
//   output register; the search reads one entry per cycle from the read port.
// Reset: table empty, entries_in_use 16, no result pending.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module height_track_table
  import htt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [63:0]       s_axis_tdata,   // record_id[31:0], position_z[63:32]
  input  logic              s_axis_tuser,   // opcode[0]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,   // height_change[31:0]
  output logic [1:0]        m_axis_tuser,   // seen[0], rejected[1]
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]  pwdata,
  output logic [APB_W-1:0]  prdata,
  output logic              pready
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EVICT,
    ST_DONE
  } state_e;

  state_e           state_q;
  logic [CFG_W-1:0] cfg_q;
  logic [CFG_W-1:0] n_sat;
  logic [CFG_W-1:0] n_q;
  logic [CFG_W-1:0] cnt_q;
  logic             chk_q;
  logic [IDX_W-1:0] chk_idx_q;
  logic             have_free_q;
  logic [IDX_W-1:0] free_at_q;
  logic [ID_W-1:0]  rid_q;
  logic [Z_W-1:0]   z_q;
  logic             res_seen_q;
  logic             res_rej_q;
  logic [Z_W-1:0]   res_chg_q;
  logic             m_valid_q;
  logic             m_seen_q;
  logic             m_rej_q;
  logic [Z_W-1:0]   m_chg_q;

  htt_mem_ctl_t     ctl;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [ID_W-1:0]  rd_id;
  logic [Z_W-1:0]   rd_height;
  logic             rem_done;
  logic [CFG_W-1:0] rem;
  logic             acc;
  logic             in_op;
  logic [ID_W-1:0]  in_rid;
  logic [Z_W-1:0]   in_z;
  logic             rem_start;
  logic             issue;
  logic             hit;
  logic             sdone;
  logic [Z_W:0]     diff;
  logic [Z_W-1:0]   chg_sat;
  logic             cfg_wr;

  assign in_op  = s_axis_tuser;
  assign in_rid = s_axis_tdata[ID_W-1:0];
  assign in_z   = s_axis_tdata[ID_W+Z_W-1:ID_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign acc           = s_axis_tvalid && s_axis_tready;

  assign n_sat = (32'(cfg_q) > TABLE_ENTRIES) ? CFG_W'(TABLE_ENTRIES) : cfg_q;

  always_comb begin
    rem_start = acc && (in_op == OP_TRACK) && (in_rid != '0) && (n_sat != '0);
    issue     = (state_q == ST_SEARCH) && (cnt_q < n_q);
    hit       = (state_q == ST_SEARCH) && chk_q && (rd_id == rid_q);
    sdone     = (state_q == ST_SEARCH) && !chk_q && !issue;

    diff    = {z_q[Z_W-1], z_q} - {rd_height[Z_W-1], rd_height};
    chg_sat = diff[Z_W-1:0];
    if (diff[Z_W] != diff[Z_W-1]) begin
      chg_sat = diff[Z_W] ? {1'b1, {(Z_W-1){1'b0}}} : {1'b0, {(Z_W-1){1'b1}}};
    end

    ctl.rd_en = issue;
    ctl.clr   = acc && (in_op == OP_CLEAR);
    ctl.wr_en = 1'b0;
    rd_addr   = IDX_W'(cnt_q);
    wr_addr   = chk_idx_q;
    if (hit) begin
      ctl.wr_en = 1'b1;
    end else if (sdone && have_free_q) begin
      ctl.wr_en = 1'b1;
      wr_addr   = free_at_q;
    end else if ((state_q == ST_EVICT) && rem_done) begin
      ctl.wr_en = 1'b1;
      wr_addr   = IDX_W'(rem);
    end
  end

  htt_store #(
    .ENTRIES (TABLE_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .rd_addr_i   (rd_addr),
    .wr_addr_i   (wr_addr),
    .wr_id_i     (rid_q),
    .wr_height_i (z_q),
    .rd_id_o     (rd_id),
    .rd_height_o (rd_height)
  );

  htt_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (in_rid),
    .divisor_i  (n_sat),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      cnt_q       <= '0;
      chk_q       <= 1'b0;
      chk_idx_q   <= '0;
      have_free_q <= 1'b0;
      free_at_q   <= '0;
      res_seen_q  <= 1'b0;
      res_rej_q   <= 1'b0;
      res_chg_q   <= '0;
      m_valid_q   <= 1'b0;
      m_seen_q    <= 1'b0;
      m_rej_q     <= 1'b0;
      m_chg_q     <= '0;
    end else begin
      if (m_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          chk_q       <= 1'b0;
          cnt_q       <= '0;
          have_free_q <= 1'b0;
          if (acc) begin
            n_q        <= n_sat;
            res_seen_q <= 1'b0;
            res_chg_q  <= '0;
            res_rej_q  <= (in_op == OP_TRACK) && (in_rid == '0);
            state_q    <= rem_start ? ST_SEARCH : ST_DONE;
          end
        end
        ST_SEARCH: begin
          chk_q     <= issue;
          chk_idx_q <= IDX_W'(cnt_q);
          if (issue) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (hit) begin
            res_seen_q <= 1'b1;
            res_chg_q  <= chg_sat;
            state_q    <= ST_DONE;
          end else if (chk_q && (rd_id == '0) && !have_free_q) begin
            have_free_q <= 1'b1;
            free_at_q   <= chk_idx_q;
          end
          if (sdone) begin
            state_q <= have_free_q ? ST_DONE : ST_EVICT;
          end
        end
        ST_EVICT: begin
          if (rem_done) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_seen_q  <= res_seen_q;
            m_rej_q   <= res_rej_q;
            m_chg_q   <= res_chg_q;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rid_q <= '0;
      z_q   <= '0;
    end else if (acc) begin
      rid_q <= in_rid;
      z_q   <= in_z;
    end
  end

  // Config port
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_wr && (paddr[2] == REG_ENTRIES_IN_USE)) begin
      cfg_q <= pwdata[CFG_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ENTRIES_IN_USE) ? APB_W'(cfg_q) : '0;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_chg_q;
  assign m_axis_tuser  = {m_rej_q, m_seen_q};

  `ASSERT_IMPLIES(a_cnt_range, clk_i, rst_ni, state_q == ST_SEARCH, cnt_q <= n_q,
                  "search index past entry count")
  `ASSERT_IMPLIES(a_evict_idx, clk_i, rst_ni, (state_q == ST_EVICT) && rem_done,
                  rem < n_q, "eviction index past entry count")
  `ASSERT_NEXT(a_hit_seen, clk_i, rst_ni, hit, res_seen_q && (state_q == ST_DONE),
               "hit did not produce a seen result")

endmodule

/* rtl/htt_store.sv */
// ----------------------------------------------------------------------------
// htt_store
// Identifier and height memories with per-entry valid bits; an invalid
// entry reads as zero. Registered read port, single write port.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module htt_store
  import htt_pkg::*;
#(
  parameter int ENTRIES = 16,
  parameter int IDX_W   = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  htt_mem_ctl_t     ctl_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  logic [ID_W-1:0]  wr_id_i,
  input  logic [Z_W-1:0]   wr_height_i,
  output logic [ID_W-1:0]  rd_id_o,
  output logic [Z_W-1:0]   rd_height_o
);

  logic [ID_W-1:0]    id_mem [ENTRIES];
  logic [Z_W-1:0]     h_mem  [ENTRIES];
  logic [ENTRIES-1:0] vld_q;
  logic               rd_vld_q;
  logic [ID_W-1:0]    rd_id_q;
  logic [Z_W-1:0]     rd_h_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      id_mem[wr_addr_i] <= wr_id_i;
      h_mem[wr_addr_i]  <= wr_height_i;
    end
    if (ctl_i.rd_en) begin
      rd_id_q <= id_mem[rd_addr_i];
      rd_h_q  <= h_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl_i.clr) begin
        vld_q <= '0;
      end else if (ctl_i.wr_en) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_id_o     = rd_vld_q ? rd_id_q : '0;
  assign rd_height_o = rd_vld_q ? rd_h_q  : '0;

  `ASSERT_NEXT(a_clr_empties, clk_i, rst_ni, ctl_i.clr && !ctl_i.wr_en, vld_q == '0,
               "clear left a valid entry")

endmodule

/* rtl/htt_rem.sv */
// ----------------------------------------------------------------------------
// htt_rem
// Bit-serial restoring remainder of a 32-bit identifier by the entry count,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module htt_rem
  import htt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ID_W-1:0]  dividend_i,
  input  logic [CFG_W-1:0] divisor_i,
  output logic             done_o,
  output logic [CFG_W-1:0] rem_o
);

  localparam int STEP_W = $clog2(ID_W);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [ID_W-1:0]   dvd_q;
  logic [CFG_W-1:0]  dvs_q;
  logic [CFG_W-1:0]  rem_q;
  logic [CFG_W:0]    trial;
  logic [CFG_W:0]    diff;

  always_comb begin
    trial = {rem_q, dvd_q[ID_W-1]};
    diff  = trial - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      dvd_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
      dvd_q  <= dividend_i;
      dvs_q  <= divisor_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      dvd_q  <= {dvd_q[ID_W-2:0], 1'b0};
      rem_q  <= (trial >= {1'b0, dvs_q}) ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
      step_q <= step_q + 1'b1;
      if (step_q == STEP_W'(ID_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  `ASSERT_IMPLIES(a_rem_below, clk_i, rst_ni, done_q, rem_q < dvs_q,
                  "remainder not below divisor")

endmodule
